// ===== rtl/lfba_pkg.sv =====
// Shared types and constants of the lowest-free block allocator.
// Depends on nothing; imported by every module of the block.
`default_nettype none
package lfba_pkg;

  localparam int unsigned OFF_W           = 14;
  localparam int unsigned ST_W            = 2;
  localparam int unsigned ROW_BITS        = 16;
  localparam int unsigned NUM_BLOCKS_DEF  = 256;
  localparam int unsigned BLOCK_BYTES_DEF = 64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [ST_W-1:0] ST_OK           = 2'd0;
  localparam logic [ST_W-1:0] ST_EXHAUSTED    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_OFFSET   = 2'd2;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 2'd3;

  typedef struct packed {
    logic             start;
    logic [OFF_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OFF_W-1:0] quot;
    logic [OFF_W-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/lfba_div.sv =====
// Reciprocal divider of a byte offset by the fixed block size.
// Depends on lfba_pkg; the product is registered, then quotient and remainder are registered from it.
`default_nettype none
module lfba_div
  import lfba_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned SHIFT = OFF_W + $clog2(BLOCK_BYTES);
  localparam int unsigned RCP_W = OFF_W + 1;
  localparam int unsigned MUL_W = OFF_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << SHIFT) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
  localparam logic [OFF_W-1:0] DIVISOR = OFF_W'(BLOCK_BYTES);

  logic             busy_q;
  logic             done_q;
  logic [OFF_W-1:0] dvd_q;
  logic [MUL_W-1:0] mul_q, mul_d;
  logic [OFF_W-1:0] quo_q, quo_d;
  logic [OFF_W-1:0] rem_q, rem_d;

  assign mul_d = MUL_W'(req_i.dividend) * MUL_W'(RCP);
  assign quo_d = OFF_W'(mul_q >> SHIFT);
  assign rem_d = dvd_q - (quo_d * DIVISOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= req_i.start;
      done_q <= busy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      mul_q <= mul_d;
    end
    if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
`default_nettype wire

// ===== rtl/lfba_map_ram.sv =====
// Free map store: rows of sixteen free bits, one write and one registered read port.
// Depends on lfba_pkg; a row never written reads as all free.
`default_nettype none
module lfba_map_ram
  import lfba_pkg::*;
#(
  parameter int unsigned ROWS  = 16,
  parameter int unsigned ROW_W = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                we_i,
  input  wire logic [ROW_W-1:0]    waddr_i,
  input  wire logic [ROW_BITS-1:0] wdata_i,
  input  wire logic [ROW_W-1:0]    raddr_i,
  output logic [ROW_BITS-1:0]      rdata_o
);

  logic [ROW_BITS-1:0] mem [ROWS];
  logic [ROWS-1:0]     vld_q;
  logic [ROW_BITS-1:0] rdata_q;
  logic                rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '1;

endmodule
`default_nettype wire

// ===== rtl/lowest_free_block_allocator_core.sv =====
// Lowest-free fixed-size block allocator: sequencer, free map store and offset divider.
// Depends on lfba_pkg, lfba_map_ram and lfba_div.
//
// Use: one command beat on the input channel (cmd_i, free_offset_i) gives one
// result beat on the output channel (status_o, block_offset_o).
// An allocate scans the free map one sixteen-block row per cycle through the
// single read port of the map store, from the lowest row up; it stops at the
// first row that holds a free block, or after the last row when the pool is
// exhausted.
// A free divides the offset by BLOCK_BYTES in a registered reciprocal multiply,
// then, for a good offset, reads one map row and writes it unless already free.
// One command is in work at a time; in_ready_o is high only while idle, so
// a new command is taken only after the previous one has finished.
// The result sits in an output register, so the next command is taken while
// it waits; a stalled receiver holds the result and blocks only the finish of
// the following command.
// Reset marks every block free at once through per-row valid flags; no
// clearing pass is needed and in_ready_o is high as soon as reset is released.
`default_nettype none
module lowest_free_block_allocator_core
  import lfba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             cmd_i,
  input  wire logic [OFF_W-1:0] free_offset_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [ST_W-1:0]       status_o,
  output logic [OFF_W-1:0]      block_offset_o
);

  localparam int unsigned ROWS   = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BIT_W  = $clog2(ROW_BITS);
  localparam int unsigned BIX_W  = ROW_W + BIT_W;
  localparam int unsigned PROD_W = BIX_W + OFF_W;
  localparam int unsigned LAST_N = NUM_BLOCKS - (ROWS - 1) * ROW_BITS;
  localparam logic [ROW_BITS-1:0] LAST_MASK = ROW_BITS'((33'(1) << LAST_N) - 33'(1));

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FRD  = 3'd3;
  localparam logic [2:0] S_FCHK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic                cmd_q, cmd_d;
  logic [ROW_W:0]      addr_q, addr_d;
  logic [ROW_W-1:0]    crow_q, crow_d;
  logic                chk_q, chk_d;
  logic [ST_W-1:0]     st_q, st_d;
  logic [BIX_W-1:0]    bix_q, bix_d;
  logic                out_valid_q, out_valid_d;
  logic [ST_W-1:0]     out_st_q, out_st_d;
  logic [OFF_W-1:0]    out_off_q, out_off_d;

  logic                we;
  logic [ROW_W-1:0]    waddr;
  logic [ROW_BITS-1:0] wdata;
  logic [ROW_W-1:0]    raddr;
  logic [ROW_BITS-1:0] rdata;
  logic [ROW_BITS-1:0] masked;
  logic [BIT_W-1:0]    low_bit;
  logic [PROD_W-1:0]   prod;
  logic                in_acc;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  lfba_map_ram #(
    .ROWS  (ROWS),
    .ROW_W (ROW_W)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  lfba_div #(
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  assign div_req.start    = in_acc && (cmd_i == CMD_FREE);
  assign div_req.dividend = free_offset_i;

  assign masked = (crow_q == ROW_W'(ROWS - 1)) ? (rdata & LAST_MASK) : rdata;

  always_comb begin
    low_bit = '0;
    for (int b = ROW_BITS - 1; b >= 0; b--) begin
      if (masked[b]) begin
        low_bit = BIT_W'(b);
      end
    end
  end

  assign prod  = PROD_W'(bix_q) * PROD_W'(BLOCK_BYTES);
  assign raddr = (state_q == S_SCAN) ? addr_q[ROW_W-1:0] : bix_q[BIX_W-1:BIT_W];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    addr_d      = addr_q;
    crow_d      = crow_q;
    chk_d       = 1'b0;
    st_d        = st_q;
    bix_d       = bix_q;
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_off_d   = out_off_q;
    we          = 1'b0;
    waddr       = bix_q[BIX_W-1:BIT_W];
    wdata       = rdata;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cmd_d  = cmd_i;
          addr_d = '0;
          if (cmd_i == CMD_ALLOC) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_SCAN: begin
        if (chk_q && (masked != '0)) begin
          we      = 1'b1;
          waddr   = crow_q;
          wdata   = rdata & ~(ROW_BITS'(1) << low_bit);
          bix_d   = {crow_q, low_bit};
          st_d    = ST_OK;
          state_d = S_FIN;
        end else if (chk_q && (crow_q == ROW_W'(ROWS - 1))) begin
          st_d    = ST_EXHAUSTED;
          state_d = S_FIN;
        end else if (addr_q < (ROW_W + 1)'(ROWS)) begin
          chk_d  = 1'b1;
          crow_d = addr_q[ROW_W-1:0];
          addr_d = addr_q + (ROW_W + 1)'(1);
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          if ((div_rsp.rem != '0) || (div_rsp.quot >= OFF_W'(NUM_BLOCKS))) begin
            st_d    = ST_BAD_OFFSET;
            state_d = S_FIN;
          end else begin
            bix_d   = div_rsp.quot[BIX_W-1:0];
            state_d = S_FRD;
          end
        end
      end
      S_FRD: begin
        state_d = S_FCHK;
      end
      S_FCHK: begin
        if (rdata[bix_q[BIT_W-1:0]]) begin
          st_d = ST_ALREADY_FREE;
        end else begin
          we   = 1'b1;
          wdata = rdata | (ROW_BITS'(1) << bix_q[BIT_W-1:0]);
          st_d = ST_OK;
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          if ((cmd_q == CMD_ALLOC) && (st_q == ST_OK)) begin
            out_off_d = prod[OFF_W-1:0];
          end else begin
            out_off_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chk_q       <= 1'b0;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chk_q       <= chk_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    crow_q    <= crow_d;
    st_q      <= st_d;
    bix_q     <= bix_d;
    out_st_q  <= out_st_d;
    out_off_q <= out_off_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_st_q;
  assign block_offset_o = out_off_q;

endmodule
`default_nettype wire

// ===== bench/lfba_scoreboard.sv =====
// Scoreboard for the lowest-free block allocator: watches both channels,
// keeps its own free map, predicts every result beat and compares.
// Depends on lfba_pkg for widths, command and status codes.
`default_nettype none
module lfba_scoreboard
  import lfba_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_ready_i,
  input  wire logic             cmd_i,
  input  wire logic [OFF_W-1:0] free_offset_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_ready_i,
  input  wire logic [ST_W-1:0]  status_i,
  input  wire logic [OFF_W-1:0] block_offset_i,
  output int unsigned           outstanding_o,
  output int unsigned           mismatches_o,
  output int unsigned           status_seen_o [4]
);

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [OFF_W-1:0] offset;
  } alloc_result_t;

  logic [NUM_BLOCKS-1:0] free_map = '1;
  alloc_result_t         pending_results [$];
  int unsigned           mismatch_count = 0;
  int unsigned           status_count [4] = '{0, 0, 0, 0};
  longint unsigned       cycle_no = 0;

  function automatic alloc_result_t apply_command(input logic cmd,
                                                  input logic [OFF_W-1:0] offset);
    alloc_result_t res;
    int            lowest;
    int            i;
    int unsigned   blk;
    res.status = ST_OK;
    res.offset = '0;
    if (cmd == CMD_ALLOC) begin
      lowest = -1;
      for (i = NUM_BLOCKS - 1; i >= 0; i--) begin
        if (free_map[i]) lowest = i;
      end
      if (lowest < 0) begin
        res.status = ST_EXHAUSTED;
      end else begin
        free_map[lowest] = 1'b0;
        res.offset = OFF_W'(lowest * BLOCK_BYTES);
      end
    end else begin
      blk = offset / BLOCK_BYTES;
      if ((offset % BLOCK_BYTES) != 0 || blk >= NUM_BLOCKS) begin
        res.status = ST_BAD_OFFSET;
      end else if (free_map[blk]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        free_map[blk] = 1'b1;
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("scoreboard: cycle %0d: %s", cycle_no, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin
    alloc_result_t want;
    cycle_no++;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("result beat with nothing pending (status %0d offset %0d)",
                                  status_i, block_offset_i));
        end else begin
          want = pending_results.pop_front();
          if (status_i !== want.status)
            flag_mismatch($sformatf("status %0d, want %0d", status_i, want.status));
          if (block_offset_i !== want.offset)
            flag_mismatch($sformatf("block offset %0d, want %0d",
                                    block_offset_i, want.offset));
          status_count[want.status]++;
        end
      end
      if (in_valid_i && in_ready_i) begin
        pending_results.push_back(apply_command(cmd_i, free_offset_i));
      end
    end
    outstanding_o <= pending_results.size();
    mismatches_o  <= mismatch_count;
    status_seen_o <= status_count;
  end

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Top of the allocator bench: clock, reset, command stimulus and verdict.
// Depends on lfba_pkg, lowest_free_block_allocator_core and lfba_scoreboard.
`default_nettype none
module testbench
  import lfba_pkg::*;
();

  localparam int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF;
  localparam int unsigned BLOCK_BYTES = BLOCK_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned DRAIN_WAIT  = 25;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             cmd = CMD_ALLOC;
  logic [OFF_W-1:0] free_offset = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [ST_W-1:0]  status;
  logic [OFF_W-1:0] block_offset;

  int unsigned      outstanding;
  int unsigned      mismatches;
  int unsigned      status_seen [4];
  int unsigned      send_idle_pct = 0;
  int unsigned      recv_stall_pct = 0;
  int unsigned      commands_sent = 0;
  longint unsigned  cycle_count = 0;

  lowest_free_block_allocator_core #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .free_offset_i (free_offset),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .block_offset_o(block_offset)
  );

  lfba_scoreboard #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .cmd_i         (cmd),
    .free_offset_i (free_offset),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .block_offset_i(block_offset),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches),
    .status_seen_o (status_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_command(input logic c, input logic [OFF_W-1:0] offset);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    cmd         <= c;
    free_offset <= offset;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    commands_sent++;
  endtask

  task automatic wait_until_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic run_commands(input int unsigned count, input int unsigned alloc_pct,
                              input int unsigned bad_pct);
    int unsigned      n;
    int unsigned      roll;
    int unsigned      blk;
    logic [OFF_W-1:0] offset;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        send_command(CMD_ALLOC, OFF_W'($urandom));
      end else if (roll < alloc_pct + bad_pct) begin
        offset = OFF_W'($urandom);
        if (offset % BLOCK_BYTES == 0) offset[0] = 1'b1;
        send_command(CMD_FREE, offset);
      end else begin
        // favour low blocks, where the allocator hands out first
        blk = $urandom_range(0, 1) ? $urandom_range(0, NUM_BLOCKS - 1)
                                   : $urandom_range(0, NUM_BLOCKS / 4 - 1);
        send_command(CMD_FREE, OFF_W'(blk * BLOCK_BYTES));
      end
    end
  endtask

  initial begin
    send_idle_pct  = 24;
    recv_stall_pct = 67;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_command(CMD_ALLOC, '0);
    send_command(CMD_ALLOC, '1);
    send_command(CMD_FREE, OFF_W'(0));
    send_command(CMD_FREE, OFF_W'(0));
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, OFF_W'(1));
    send_command(CMD_FREE, '1);
    send_command(CMD_FREE, OFF_W'((NUM_BLOCKS - 1) * BLOCK_BYTES));
    send_command(CMD_FREE, OFF_W'(BLOCK_BYTES / 2));
    send_command(CMD_ALLOC, '0);
    send_command(CMD_FREE, OFF_W'(BLOCK_BYTES));
    send_command(CMD_ALLOC, '1);
    send_command(CMD_FREE, OFF_W'(2 * BLOCK_BYTES));
    send_command(CMD_FREE, OFF_W'(BLOCK_BYTES));
    send_command(CMD_FREE, OFF_W'(0));
    send_command(CMD_FREE, OFF_W'(128 * BLOCK_BYTES));
    send_command(CMD_FREE, OFF_W'(127 * BLOCK_BYTES + 1));
    send_command(CMD_ALLOC, OFF_W'(16'h2aaa));
    send_command(CMD_FREE, OFF_W'(0));
    wait_until_settled();

    // fill past exhaustion, then thin out
    run_commands(300, 98, 1);
    run_commands(40, 30, 20);
    wait_until_settled();

    send_idle_pct  = 67;
    recv_stall_pct = 24;
    run_commands(150, 15, 10);
    run_commands(140, 50, 15);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_commands(200, 92, 3);
    run_commands(120, 40, 20);

    wait_until_settled();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("run: %0d commands; results ok %0d, exhausted %0d, bad offset %0d, double free %0d",
             commands_sent, status_seen[ST_OK], status_seen[ST_EXHAUSTED],
             status_seen[ST_BAD_OFFSET], status_seen[ST_ALREADY_FREE]);
    $display("run: %0d mismatches over %0d cycles", mismatches, cycle_count);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
